// ===== src/sdf_pkg.sv =====
package sdf_pkg;

  // Input action codes
  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_BODY   = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  // Fixed frame bytes
  localparam logic [7:0] SYX_START     = 8'hF0;
  localparam logic [7:0] SYX_MAKER     = 8'h41;
  localparam logic [7:0] SYX_MODEL_HI  = 8'h00;
  localparam logic [7:0] SYX_MODEL_MID = 8'h00;
  localparam logic [7:0] SYX_MODEL_LO  = 8'h64;
  localparam logic [7:0] SYX_CMD_RQ1   = 8'h11;
  localparam logic [7:0] SYX_CMD_DT1   = 8'h12;
  localparam logic [7:0] SYX_END       = 8'hF7;

  localparam logic [6:0] DEVICE_ID_RST = 7'd16;

  // Command queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;

  // Byte positions within one command
  localparam logic [3:0] LAST_IDX_START  = 4'd10;
  localparam logic [3:0] LAST_IDX_BODY   = 4'd0;
  localparam logic [3:0] LAST_IDX_FINISH = 4'd1;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_BODY,
    KIND_FINISH
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic        is_request;
    logic [6:0]  device_id;
    logic [31:0] address;
    logic [7:0]  data;       // body byte, or checksum on finish
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== src/sdf_front.sv =====
module sdf_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       action_i,
  input  logic             is_request_i,
  input  logic [31:0]      address_i,
  input  logic [7:0]       body_byte_i,
  input  logic             cfg_we_i,
  input  logic [6:0]       cfg_wdata_i,
  input  sdf_pkg::q_stat_t q_stat_i,
  output logic             in_ready_o,
  output logic             push_o,
  output sdf_pkg::cmd_t    cmd_o
);

  logic [6:0] device_id_q, device_id_d;
  logic [6:0] sum_q, sum_d;
  logic [6:0] addr_sum;
  logic       accept;
  logic       known;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  // Only the low seven bits of each byte matter modulo 128
  assign addr_sum = address_i[30:24] + address_i[22:16] + address_i[14:8] + address_i[6:0];

  always_comb begin
    known             = 1'b1;
    sum_d             = sum_q;
    cmd_o.kind        = sdf_pkg::KIND_BODY;
    cmd_o.is_request  = is_request_i;
    cmd_o.device_id   = device_id_q;
    cmd_o.address     = address_i;
    cmd_o.data        = body_byte_i;
    case (action_i)
      sdf_pkg::ACT_START: begin
        cmd_o.kind = sdf_pkg::KIND_START;
        sum_d      = addr_sum;
      end
      sdf_pkg::ACT_BODY: begin
        cmd_o.kind = sdf_pkg::KIND_BODY;
        sum_d      = sum_q + body_byte_i[6:0];
      end
      sdf_pkg::ACT_FINISH: begin
        cmd_o.kind = sdf_pkg::KIND_FINISH;
        cmd_o.data = {1'b0, 7'(7'd0 - sum_q)};
        sum_d      = '0;
      end
      default: begin
        known = 1'b0;   // drop unused code
      end
    endcase
  end

  assign push_o      = accept && known;
  assign device_id_d = cfg_we_i ? cfg_wdata_i : device_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_id_q <= sdf_pkg::DEVICE_ID_RST;
      sum_q       <= '0;
    end else begin
      device_id_q <= device_id_d;
      if (push_o) begin
        sum_q <= sum_d;
      end
    end
  end

endmodule

// ===== src/sdf_queue.sv =====
module sdf_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sdf_pkg::cmd_t    cmd_i,
  input  logic             pop_i,
  output sdf_pkg::cmd_t    head_o,
  output sdf_pkg::q_stat_t stat_o
);

  sdf_pkg::cmd_t                 mem_q [sdf_pkg::QDepth];
  logic [sdf_pkg::QPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [sdf_pkg::QPtrW:0]       cnt_q;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == (sdf_pkg::QPtrW + 1)'(sdf_pkg::QDepth));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== src/sdf_back.sv =====
module sdf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sdf_pkg::cmd_t    head_i,
  input  sdf_pkg::q_stat_t q_stat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             last_o
);

  sdf_pkg::cmd_t cur_q;
  logic          cur_vld_q;
  logic [3:0]    idx_q;
  logic          out_vld_q;
  logic [7:0]    out_byte_q;
  logic          last_q;
  logic          adv;
  logic          emit;
  logic [3:0]    last_idx;
  logic          at_last;
  logic [7:0]    byte_d;

  assign adv  = !out_vld_q || out_ready_i;
  assign emit = adv && cur_vld_q;

  always_comb begin
    case (cur_q.kind)
      sdf_pkg::KIND_START:  last_idx = sdf_pkg::LAST_IDX_START;
      sdf_pkg::KIND_FINISH: last_idx = sdf_pkg::LAST_IDX_FINISH;
      default:              last_idx = sdf_pkg::LAST_IDX_BODY;
    endcase
  end

  assign at_last = (idx_q == last_idx);
  assign pop_o   = !q_stat_i.empty && (!cur_vld_q || (emit && at_last));

  always_comb begin
    byte_d = cur_q.data;
    case (cur_q.kind)
      sdf_pkg::KIND_START: begin
        case (idx_q)
          4'd0:    byte_d = sdf_pkg::SYX_START;
          4'd1:    byte_d = sdf_pkg::SYX_MAKER;
          4'd2:    byte_d = {1'b0, cur_q.device_id};
          4'd3:    byte_d = sdf_pkg::SYX_MODEL_HI;
          4'd4:    byte_d = sdf_pkg::SYX_MODEL_MID;
          4'd5:    byte_d = sdf_pkg::SYX_MODEL_LO;
          4'd6:    byte_d = cur_q.is_request ? sdf_pkg::SYX_CMD_RQ1 : sdf_pkg::SYX_CMD_DT1;
          4'd7:    byte_d = cur_q.address[31:24];
          4'd8:    byte_d = cur_q.address[23:16];
          4'd9:    byte_d = cur_q.address[15:8];
          default: byte_d = cur_q.address[7:0];
        endcase
      end
      sdf_pkg::KIND_FINISH: begin
        byte_d = (idx_q == '0) ? cur_q.data : sdf_pkg::SYX_END;
      end
      default: begin
        byte_d = cur_q.data;
      end
    endcase
  end

  // Load the next command from the queue head, and register each emitted byte with its last flag
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
    if (emit) begin
      out_byte_q <= byte_d;
      last_q     <= at_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (pop_o) begin
        cur_vld_q <= 1'b1;
        idx_q     <= '0;
      end else if (emit) begin
        if (at_last) begin
          cur_vld_q <= 1'b0;
          idx_q     <= '0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      if (adv) begin
        out_vld_q <= cur_vld_q;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

endmodule

// ===== src/sysex_request_data_framer.sv =====
// System-exclusive DT1/RQ1 frame builder. Each transfer on the input side
// is a start, body or finish action; the block answers with frame bytes on
// the output, one byte per transfer, with last_o marking the final byte of
// each action. A start produces eleven bytes (F0, maker, device id, model
// id, command, four address bytes MSB first), a body action one byte and a
// finish action two (checksum, F7). The front end takes one input transfer
// per cycle while its four-entry command queue has room, keeps the running
// checksum and drops the unused action code; the back end emits one byte
// per cycle while the receiver is ready, through a registered output stage.
// Sustained input rate is thus set by the output byte rate. The device id
// register (reset 0x10) is written by cfg_we_i / cfg_wdata_i and must only
// change while the block is idle.
module sysex_request_data_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic        is_request_i,
  input  logic [31:0] address_i,
  input  logic [7:0]  body_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);

  sdf_pkg::cmd_t    push_cmd;
  sdf_pkg::cmd_t    head_cmd;
  sdf_pkg::q_stat_t q_stat;
  logic             push;
  logic             pop;

  // Front end: classify actions, track checksum, enqueue commands
  sdf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .action_i     (action_i),
    .is_request_i (is_request_i),
    .address_i    (address_i),
    .body_byte_i  (body_byte_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_stat_i     (q_stat),
    .in_ready_o   (in_ready_o),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  // Decouple the two halves
  sdf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .head_o (head_cmd),
    .stat_o (q_stat)
  );

  // Back end: serialise each command into frame bytes
  sdf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

  // Never enqueue into a full queue
  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("command pushed into full queue");

  // Never dequeue from an empty queue
  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("command popped from empty queue");

  // Every accepted known action reaches the queue
  a_known_pushed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (action_i == sdf_pkg::ACT_START ||
      action_i == sdf_pkg::ACT_BODY || action_i == sdf_pkg::ACT_FINISH)) |-> push)
    else $error("accepted action not enqueued");

  // An empty queue stays empty until something is pushed
  a_empty_after_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_stat.empty && !push) |=> q_stat.empty || $past(push))
    else $error("queue left empty state without a push");

endmodule

// ===== sim/tb.sv =====
module tb;

  // Action code the block must drop without a trace
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Receiver hold-off used to fill the command queue and stall the input
  localparam int HOLD_CYCLES = 300;
  // Cycles to let the front end settle after the last expected byte
  localparam int SETTLE_CYCLES = 20;
  // Cycles without any transfer before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;

  // One expected output byte of a frame
  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  // Tracks device id and checksum state, and holds the bytes still owed by the block
  class frame_byte_board;
    logic [6:0]  dev_id;
    logic [6:0]  addr_body_sum;
    frame_byte_t due[$];
    int          errors;

    function new();
      dev_id        = sdf_pkg::DEVICE_ID_RST;
      addr_body_sum = '0;
      errors        = 0;
    endfunction

    function void owe_byte(logic [7:0] b, logic l);
      frame_byte_t fb;
      fb.data = b;
      fb.last = l;
      due.insert(due.size(), fb);
    endfunction

    // Work out the bytes that one accepted action must produce
    function void note_action(logic [1:0] act, logic req, logic [31:0] addr,
                              logic [7:0] body);
      logic [7:0] ab;
      case (act)
        sdf_pkg::ACT_START: begin
          owe_byte(sdf_pkg::SYX_START, 1'b0);
          owe_byte(sdf_pkg::SYX_MAKER, 1'b0);
          owe_byte({1'b0, dev_id}, 1'b0);
          owe_byte(sdf_pkg::SYX_MODEL_HI, 1'b0);
          owe_byte(sdf_pkg::SYX_MODEL_MID, 1'b0);
          owe_byte(sdf_pkg::SYX_MODEL_LO, 1'b0);
          owe_byte(req ? sdf_pkg::SYX_CMD_RQ1 : sdf_pkg::SYX_CMD_DT1, 1'b0);
          addr_body_sum = '0;
          for (int i = 3; i >= 0; i--) begin
            ab = addr[8*i +: 8];
            addr_body_sum = addr_body_sum + ab[6:0];
            owe_byte(ab, i == 0);
          end
        end
        sdf_pkg::ACT_BODY: begin
          owe_byte(body, 1'b1);
          addr_body_sum = addr_body_sum + body[6:0];
        end
        sdf_pkg::ACT_FINISH: begin
          owe_byte({1'b0, 7'd0 - addr_body_sum}, 1'b0);
          owe_byte(sdf_pkg::SYX_END, 1'b1);
          addr_body_sum = '0;
        end
        default: ;
      endcase
    endfunction

    function void check_byte(logic [7:0] got, logic got_last);
      frame_byte_t want;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 200)
          $display("%0t: unexpected byte %02h (last %0b), nothing owed", $time, got,
                   got_last);
        return;
      end
      want = due.pop_front();
      if (got !== want.data) begin
        errors++;
        if (errors <= 200)
          $display("%0t: out_byte expected %02h actual %02h", $time, want.data, got);
      end
      if (got_last !== want.last) begin
        errors++;
        if (errors <= 200)
          $display("%0t: last expected %0b actual %0b", $time, want.last, got_last);
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [6:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  action_i;
  logic        is_request_i;
  logic [31:0] address_i;
  logic [7:0]  body_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_byte_o;
  logic        last_o;

  frame_byte_board board;

  // Idle chances in percent for each side, changed between phases
  int send_idle_pct;
  int recv_idle_pct;
  // Set by the sender to make the receiver back off for a long stretch
  bit hold_req;
  int quiet_cycles;

  sysex_request_data_framer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .is_request_i (is_request_i),
    .address_i    (address_i),
    .body_byte_i  (body_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Offer one action and hold it until the block takes it. Called and left at a
  // falling edge; valid stays high on return so back-to-back transfers need no gap.
  task automatic send_item(input logic [1:0] act, input logic req, input logic [31:0] addr,
                           input logic [7:0] body);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    is_request_i <= req;
    address_i    <= addr;
    body_byte_i  <= body;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_action(act, req, addr, body);
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every owed byte, then give the front end time to
  // swallow any trailing unused actions.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_device_id(input logic [6:0] id);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= id;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.dev_id = id;
  endtask

  // Mostly well-formed frames with random content; now and then a stray action
  // of any code, or a frame left open with no finish.
  task automatic run_random(input int target);
    int         sent;
    int         n_body;
    logic [1:0] act;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(7) == 0) begin
        act = 2'($urandom_range(3));
        send_item(act, 1'($urandom), $urandom, 8'($urandom));
        if (act != ACT_UNUSED) sent++;
      end else begin
        send_item(sdf_pkg::ACT_START, 1'($urandom), $urandom, 8'($urandom));
        n_body = $urandom_range(6);
        repeat (n_body) send_item(sdf_pkg::ACT_BODY, 1'($urandom), $urandom, 8'($urandom));
        sent += 1 + n_body;
        if ($urandom_range(9) != 0) begin
          send_item(sdf_pkg::ACT_FINISH, 1'($urandom), $urandom, 8'($urandom));
          sent++;
        end
      end
    end
  endtask

  // Receiver: back off at random, or for a long counted stretch on request
  initial begin : receiver
    int hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Check every byte transfer on the output side against the oldest owed byte
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_byte(out_byte_o, last_o);
  end

  // Advance the quiet counter on every cycle with no transfer on either side, and end the run at the watchdog limit
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transfer for %0d cycles, %0d bytes owed", $time,
               quiet_cycles, board.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    board         = new();
    send_idle_pct = 9;
    recv_idle_pct = 45;
    hold_req      = 1'b0;
    quiet_cycles  = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    action_i      = sdf_pkg::ACT_START;
    is_request_i  = 1'b0;
    address_i     = '0;
    body_byte_i   = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, with the device id still at its reset value.
    // Body and finish with no frame open: the sum starts from zero.
    send_item(sdf_pkg::ACT_BODY, 1'($urandom), $urandom, 8'hFF);
    send_item(sdf_pkg::ACT_FINISH, 1'($urandom), $urandom, 8'($urandom));
    // Unused code between frames, then a finish on an empty sum
    send_item(ACT_UNUSED, 1'($urandom), $urandom, 8'($urandom));
    send_item(sdf_pkg::ACT_FINISH, 1'($urandom), $urandom, 8'($urandom));
    // Data-set frame, all-zero address and body
    send_item(sdf_pkg::ACT_START, 1'b0, 32'h0000_0000, 8'($urandom));
    send_item(sdf_pkg::ACT_BODY, 1'($urandom), $urandom, 8'h00);
    send_item(sdf_pkg::ACT_FINISH, 1'($urandom), $urandom, 8'($urandom));
    // Request frame, all-ones address, body bytes with and without the top bit
    send_item(sdf_pkg::ACT_START, 1'b1, 32'hFFFF_FFFF, 8'($urandom));
    send_item(sdf_pkg::ACT_BODY, 1'($urandom), $urandom, 8'h80);
    send_item(sdf_pkg::ACT_BODY, 1'($urandom), $urandom, 8'h7F);
    send_item(sdf_pkg::ACT_BODY, 1'($urandom), $urandom, 8'hFF);
    send_item(sdf_pkg::ACT_FINISH, 1'($urandom), $urandom, 8'($urandom));
    // Unused code in the middle of a frame must leave the sum alone
    send_item(sdf_pkg::ACT_START, 1'b0, 32'h1234_5678, 8'($urandom));
    send_item(ACT_UNUSED, 1'($urandom), $urandom, 8'($urandom));
    send_item(sdf_pkg::ACT_BODY, 1'($urandom), $urandom, 8'h01);
    send_item(sdf_pkg::ACT_FINISH, 1'($urandom), $urandom, 8'($urandom));
    // Frame with no body, then a start over an open frame
    send_item(sdf_pkg::ACT_START, 1'b1, 32'h8000_0001, 8'($urandom));
    send_item(sdf_pkg::ACT_FINISH, 1'($urandom), $urandom, 8'($urandom));
    send_item(sdf_pkg::ACT_START, 1'b0, 32'h7F80_FF01, 8'($urandom));
    send_item(sdf_pkg::ACT_BODY, 1'($urandom), $urandom, 8'hC3);
    send_item(sdf_pkg::ACT_START, 1'b1, 32'h0102_0304, 8'($urandom));
    send_item(sdf_pkg::ACT_FINISH, 1'($urandom), $urandom, 8'($urandom));
    settle();

    // Sender mostly busy, receiver slow; open with a long receiver hold-off
    // so the command queue fills and the input stalls.
    write_device_id(7'd127);
    hold_req = 1'b1;
    run_random(130);
    settle();

    // Sender slow, receiver mostly ready
    write_device_id(7'd0);
    send_idle_pct = 45;
    recv_idle_pct = 9;
    run_random(130);
    settle();

    // Neither side idles
    write_device_id(7'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(130);
    settle();

    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/sdf_pkg.sv
src/sdf_front.sv
src/sdf_queue.sv
src/sdf_back.sv
src/sysex_request_data_framer.sv
sim/tb.sv
